@@ src/field_relative_mecanum_mixer_macros.svh @@
// ----------------------------------------------------------------------------
// Mecanum mixer assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FIELD_RELATIVE_MECANUM_MIXER_MACROS_SVH
`define FIELD_RELATIVE_MECANUM_MIXER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FRMM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frmm check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define FRMM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frmm check failed");

`endif

@@ src/frmm_pkg.sv @@
// ----------------------------------------------------------------------------
// frmm_pkg
// Widths, constants and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package frmm_pkg;

  localparam int SINE_TABLE_BITS_DEF = 8;
  localparam int FRAC_BITS_DEF       = 14;

  localparam int IN_W   = 16;  // command and angle width
  localparam int OUT_W  = 17;  // wheel drive width
  localparam int ROM_W  = 31;  // unsigned table entry, Q30 times sqrt2
  localparam int SIN_W  = 32;  // signed sine / cosine
  localparam int PROD_W = SIN_W + IN_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - 30;  // diagonal after dropping 30 fraction bits
  localparam int CLP_W  = 33;          // compare width for the +-1.0 clamp

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SQRT2_Q30   = 64'd1518500250;
  localparam longint      ONE_Q30     = 64'sd1073741824;

  // Taylor term divisor (2k)(2k+1)
  function automatic logic [63:0] div_k(input logic [63:0] v, input int unsigned k);
    case (k)
      1:       div_k = v / 6;
      2:       div_k = v / 20;
      3:       div_k = v / 42;
      4:       div_k = v / 72;
      5:       div_k = v / 110;
      6:       div_k = v / 156;
      default: div_k = v / 210;
    endcase
  endfunction

  // sqrt2 * sin(idx * 90deg / 2^bits) in Q30, built from a fixed-point series
  function automatic logic [ROM_W-1:0] tbl_entry(input int unsigned idx,
                                                 input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] prod;
    longint      sum;
    int unsigned k;
    x    = ((64'(idx) * HALF_PI_Q30) + (64'd1 << (bits - 1))) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 7; k++) begin
      term = div_k((term * x2) >> 30, k);
      if ((k & 1) == 1)
        sum = sum - longint'(term);
      else
        sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    prod = (64'(sum) * SQRT2_Q30) + (64'd1 << 29);
    tbl_entry = prod[30 +: ROM_W];
  endfunction

endpackage

@@ src/frmm_sine.sv @@
// ----------------------------------------------------------------------------
// frmm_sine
// Two-stage sine/cosine of (45deg - heading): index prep, then table read.
// ----------------------------------------------------------------------------
module frmm_sine #(
  parameter int SINE_TABLE_BITS = frmm_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               en_a,
  input  logic                               en_b,
  input  logic [frmm_pkg::IN_W-1:0]          heading,
  output logic signed [frmm_pkg::SIN_W-1:0]  sin_val,
  output logic signed [frmm_pkg::SIN_W-1:0]  cos_val
);

  localparam int TBL_N = 1 << SINE_TABLE_BITS;
  localparam int IDX_W = SINE_TABLE_BITS + 1;

  logic [frmm_pkg::ROM_W-1:0] rom [TBL_N+1];

  for (genvar g = 0; g <= TBL_N; g++) begin : g_rom
    assign rom[g] = frmm_pkg::tbl_entry(g, SINE_TABLE_BITS);
  end

  logic [frmm_pkg::IN_W-1:0] ang_s;
  logic [frmm_pkg::IN_W-1:0] ang_c;
  logic [SINE_TABLE_BITS-1:0] raw_s;
  logic [SINE_TABLE_BITS-1:0] raw_c;
  logic [IDX_W-1:0] idx_s_next;
  logic [IDX_W-1:0] idx_c_next;
  logic [IDX_W-1:0] idx_s;
  logic [IDX_W-1:0] idx_c;
  logic neg_s;
  logic neg_c;
  logic [frmm_pkg::ROM_W-1:0] mag_s;
  logic [frmm_pkg::ROM_W-1:0] mag_c;

  always_comb begin
    ang_s = 16'h2000 - heading;
    ang_c = ang_s + 16'h4000;   // cos(a) = sin(a + 90deg)
    raw_s = ang_s[13 -: SINE_TABLE_BITS];
    raw_c = ang_c[13 -: SINE_TABLE_BITS];
    // odd quadrants read the table mirrored
    idx_s_next = ang_s[14] ? (IDX_W'(TBL_N) - {1'b0, raw_s}) : {1'b0, raw_s};
    idx_c_next = ang_c[14] ? (IDX_W'(TBL_N) - {1'b0, raw_c}) : {1'b0, raw_c};
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      idx_s <= idx_s_next;
      idx_c <= idx_c_next;
      neg_s <= ang_s[15];
      neg_c <= ang_c[15];
    end
  end

  assign mag_s = rom[idx_s];
  assign mag_c = rom[idx_c];

  always_ff @(posedge clk) begin
    if (en_b) begin
      sin_val <= neg_s ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
      cos_val <= neg_c ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end
  end

endmodule

@@ src/frmm_mult.sv @@
// ----------------------------------------------------------------------------
// frmm_mult
// One register stage of the four rotation products.
// ----------------------------------------------------------------------------
module frmm_mult (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [frmm_pkg::SIN_W-1:0]   sin_val,
  input  logic signed [frmm_pkg::SIN_W-1:0]   cos_val,
  input  logic signed [frmm_pkg::IN_W-1:0]    forward_back,
  input  logic signed [frmm_pkg::IN_W-1:0]    left_right,
  output logic signed [frmm_pkg::PROD_W-1:0]  cos_fb,
  output logic signed [frmm_pkg::PROD_W-1:0]  sin_lr,
  output logic signed [frmm_pkg::PROD_W-1:0]  sin_fb,
  output logic signed [frmm_pkg::PROD_W-1:0]  cos_lr
);

  always_ff @(posedge clk) begin
    if (en) begin
      cos_fb <= cos_val * forward_back;
      sin_lr <= sin_val * left_right;
      sin_fb <= sin_val * forward_back;
      cos_lr <= cos_val * left_right;
    end
  end

endmodule

@@ src/frmm_mix.sv @@
// ----------------------------------------------------------------------------
// frmm_mix
// Diagonal sums with rounding, then clamp to +-1.0 and add/subtract turn.
// ----------------------------------------------------------------------------
module frmm_mix #(
  parameter int FRAC_BITS = frmm_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en_d,
  input  logic                                en_e,
  input  logic signed [frmm_pkg::PROD_W-1:0]  cos_fb,
  input  logic signed [frmm_pkg::PROD_W-1:0]  sin_lr,
  input  logic signed [frmm_pkg::PROD_W-1:0]  sin_fb,
  input  logic signed [frmm_pkg::PROD_W-1:0]  cos_lr,
  input  logic signed [frmm_pkg::IN_W-1:0]    turn_rate,
  output logic [frmm_pkg::OUT_W-1:0]          front_left_drive,
  output logic [frmm_pkg::OUT_W-1:0]          back_right_drive,
  output logic [frmm_pkg::OUT_W-1:0]          front_right_drive,
  output logic [frmm_pkg::OUT_W-1:0]          back_left_drive
);

  localparam logic signed [frmm_pkg::CLP_W-1:0] ONE     = frmm_pkg::CLP_W'(1) << FRAC_BITS;
  localparam logic signed [frmm_pkg::CLP_W-1:0] NEG_ONE = -ONE;
  localparam logic signed [frmm_pkg::SUM_W-1:0] HALF    = frmm_pkg::SUM_W'(1) << 29;

  logic signed [frmm_pkg::SUM_W-1:0] sum_x;
  logic signed [frmm_pkg::SUM_W-1:0] sum_y;
  logic signed [frmm_pkg::RND_W-1:0] rx;
  logic signed [frmm_pkg::RND_W-1:0] ry;
  logic signed [frmm_pkg::CLP_W-1:0] wx;
  logic signed [frmm_pkg::CLP_W-1:0] wy;
  logic signed [frmm_pkg::CLP_W-1:0] cx;
  logic signed [frmm_pkg::CLP_W-1:0] cy;
  logic [frmm_pkg::OUT_W-1:0] x17;
  logic [frmm_pkg::OUT_W-1:0] y17;
  logic [frmm_pkg::OUT_W-1:0] t17;

  // round half up: add half an LSB, keep the top bits
  always_comb begin
    sum_x = frmm_pkg::SUM_W'(cos_fb) + frmm_pkg::SUM_W'(sin_lr) + HALF;
    sum_y = frmm_pkg::SUM_W'(sin_fb) - frmm_pkg::SUM_W'(cos_lr) + HALF;
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      rx <= sum_x[frmm_pkg::SUM_W-1:30];
      ry <= sum_y[frmm_pkg::SUM_W-1:30];
    end
  end

  always_comb begin
    wx = frmm_pkg::CLP_W'(rx);
    wy = frmm_pkg::CLP_W'(ry);
    cx = (wx > ONE) ? ONE : ((wx < NEG_ONE) ? NEG_ONE : wx);
    cy = (wy > ONE) ? ONE : ((wy < NEG_ONE) ? NEG_ONE : wy);
    x17 = cx[frmm_pkg::OUT_W-1:0];
    y17 = cy[frmm_pkg::OUT_W-1:0];
    t17 = frmm_pkg::OUT_W'(turn_rate);
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      front_left_drive  <= x17 + t17;
      back_right_drive  <= x17 - t17;
      front_right_drive <= y17 - t17;
      back_left_drive   <= y17 + t17;
    end
  end

endmodule

@@ src/field_relative_mecanum_mixer.sv @@
// ----------------------------------------------------------------------------
// field_relative_mecanum_mixer
// Field-oriented mecanum mixer: drive commands and heading to four wheels.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command beat: forward/back, strafe, turn (signed
//   Q1.14) and the robot heading (16-bit binary angle). m_axis returns one
//   beat of four wheel drives (signed Q2.14, 17 bits each) per command.
// Stages: index prep, sine table read, rotation multiply, round, clamp/turn
//   mix; m_axis_tvalid is the valid bit of the last stage.
// Throughput: one beat per cycle while m_axis_tready is high. Each stage has
//   its own valid bit and advances when empty or when the stage after it
//   advances, so bubbles fill up; the four 32x16 multipliers in the multiply
//   stage set the clock budget.
// Stall: when m_axis_tready is low, the output beat holds and the stages
//   behind it keep filling; s_axis_tready drops only once all five stages
//   hold beats. Nothing is dropped or repeated.
// Reset: rst (synchronous) clears the valid bits only; the sine table is
//   constant logic and needs no fill.
// ----------------------------------------------------------------------------
`include "field_relative_mecanum_mixer_macros.svh"

module field_relative_mecanum_mixer #(
  parameter int SINE_TABLE_BITS = frmm_pkg::SINE_TABLE_BITS_DEF,
  parameter int FRAC_BITS       = frmm_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] forward_back, [31:16] left_right, [47:32] turn_rate,
  // [63:48] heading_angle
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [16:0] front_left_drive, [33:17] back_right_drive,
  // [50:34] front_right_drive, [67:51] back_left_drive, [71:68] zero
  output logic [71:0] m_axis_tdata
);

  localparam int NSTG = 5;

  logic [NSTG:1] vld;    // per-stage valid
  logic [NSTG:1] adv;    // per-stage load enable

  // ---- input fields
  logic signed [frmm_pkg::IN_W-1:0] in_fb;
  logic signed [frmm_pkg::IN_W-1:0] in_lr;
  logic signed [frmm_pkg::IN_W-1:0] in_turn;
  logic [frmm_pkg::IN_W-1:0]        in_head;

  assign in_fb   = s_axis_tdata[15:0];
  assign in_lr   = s_axis_tdata[31:16];
  assign in_turn = s_axis_tdata[47:32];
  assign in_head = s_axis_tdata[63:48];

  // ---- pipeline control: a stage loads when empty or when it drains
  always_comb begin
    adv[NSTG] = !vld[NSTG] || m_axis_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= s_axis_tvalid;
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---- side payload delay lines
  logic signed [frmm_pkg::IN_W-1:0] fb1, fb2, lr1, lr2;
  logic signed [frmm_pkg::IN_W-1:0] turn1, turn2, turn3, turn4;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      fb1   <= in_fb;
      lr1   <= in_lr;
      turn1 <= in_turn;
    end
    if (adv[2]) begin
      fb2   <= fb1;
      lr2   <= lr1;
      turn2 <= turn1;
    end
    if (adv[3]) turn3 <= turn2;
    if (adv[4]) turn4 <= turn3;
  end

  // ---- stages 1-2: sine / cosine of (45deg - heading)
  logic signed [frmm_pkg::SIN_W-1:0] sin_val;
  logic signed [frmm_pkg::SIN_W-1:0] cos_val;

  frmm_sine #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk     (clk),
    .en_a    (adv[1]),
    .en_b    (adv[2]),
    .heading (in_head),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  // ---- stage 3: rotation products
  logic signed [frmm_pkg::PROD_W-1:0] cos_fb, sin_lr, sin_fb, cos_lr;

  frmm_mult u_mult (
    .clk          (clk),
    .en           (adv[3]),
    .sin_val      (sin_val),
    .cos_val      (cos_val),
    .forward_back (fb2),
    .left_right   (lr2),
    .cos_fb       (cos_fb),
    .sin_lr       (sin_lr),
    .sin_fb       (sin_fb),
    .cos_lr       (cos_lr)
  );

  // ---- stages 4-5: round, clamp, turn mix
  logic [frmm_pkg::OUT_W-1:0] fl_drv, br_drv, fr_drv, bl_drv;

  frmm_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk               (clk),
    .en_d              (adv[4]),
    .en_e              (adv[5]),
    .cos_fb            (cos_fb),
    .sin_lr            (sin_lr),
    .sin_fb            (sin_fb),
    .cos_lr            (cos_lr),
    .turn_rate         (turn4),
    .front_left_drive  (fl_drv),
    .back_right_drive  (br_drv),
    .front_right_drive (fr_drv),
    .back_left_drive   (bl_drv)
  );

  assign m_axis_tvalid = vld[NSTG];
  assign m_axis_tdata  = {4'b0000, bl_drv, fr_drv, br_drv, fl_drv};

  // ---- checks
  // both wheel pairs see the same turn: fl - br == bl - fr == 2*turn
  logic [frmm_pkg::OUT_W-1:0] diff_x, diff_y;
  assign diff_x = fl_drv - br_drv;
  assign diff_y = bl_drv - fr_drv;

  `FRMM_ASSERT_IMP(a_empty_out_ready, !m_axis_tvalid, s_axis_tready)
  `FRMM_ASSERT_IMP(a_adv_chain, adv[NSTG], adv[1] && adv[2] && adv[3] && adv[4])
  `FRMM_ASSERT_IMP(a_turn_aligned, m_axis_tvalid, diff_x == diff_y)
  `FRMM_ASSERT_NXT(a_stall_holds, vld[4] && !adv[5], vld[4] && vld[5])

endmodule
